>>> hdl/hcbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants of the chunked body decoder
// Phase codes, status codes, line delimiters and the hex digit decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int unsigned ACC_W    = 33;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;

    localparam logic [BYTE_W-1:0]  CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0]  CHAR_LF = 8'h0A;

    localparam logic [COUNT_W-1:0] MAX_BODY_RESET = 32'd1048576;
    localparam logic [ACC_W-1:0]   ACC_SAT        = {ACC_W{1'b1}};

    // decode_status codes
    localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BIG   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd3;

    typedef enum logic [6:0] {
        PH_DIGITS     = 7'b0000001,
        PH_REST       = 7'b0000010,
        PH_DATA       = 7'b0000100,
        PH_SKIP       = 7'b0001000,
        PH_DONE_OK    = 7'b0010000,
        PH_DONE_BIG   = 7'b0100000,
        PH_DONE_TRUNC = 7'b1000000
    } phase_t;

    // {is_digit, value}
    typedef struct packed {
        logic       is_digit;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_digit_t h;
        logic [BYTE_W-1:0] t;
        h = '0;
        t = '0;
        if (c inside {[8'h30:8'h39]})
        begin
            t = c - 8'h30;
            h.is_digit = 1'b1;
            h.value    = t[3:0];
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            t = c - 8'h57;
            h.is_digit = 1'b1;
            h.value    = t[3:0];
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            t = c - 8'h37;
            h.is_digit = 1'b1;
            h.value    = t[3:0];
        end
        return h;
    endfunction

endpackage
`default_nettype wire

>>> hdl/http_chunked_body_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer body decoder
// Strips chunk size lines and the line end after each chunk's data, passes payload bytes through.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received body byte per transaction in tdata; a
//   transaction with tlast high marks end of connection and its tdata is
//   ignored. Every input transaction yields exactly one m_axis transaction:
//   tdata is the payload byte (zero when not payload), tuser[0] flags a
//   payload byte, tuser[2:1] is the decode status (busy, complete, too
//   large, truncated) and tlast is high on the first terminal status only.
//   cfg carries max_body_bytes; it is always ready and is to be written only
//   while the decoder is idle. A new limit is used at the next size line end.
//   The output register holds each result in the cycle after its input. One byte
//   per cycle while m_axis_tready is high: the whole state update is combinational
//   between the decoder state registers and the output register.
//   While the receiver stalls with a result held, s_axis_tready follows
//   m_axis_tready, so the result register drains and refills in the same cycle.
//   Reset clears the state to the start of a body and the limit to 1 MiB;
//   once a terminal status is reached only reset starts a new body.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [hcbd_pkg::COUNT_W-1:0]  cfg_data,      // max_body_bytes
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    input  wire logic                          s_axis_tlast,  // end_of_input
    // output stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // [7:0] body_byte
    output logic [2:0]                         m_axis_tuser,  // [0] body_valid,
                                                              // [2:1] decode_status
    output logic                               m_axis_tlast   // final_flag
);
    import hcbd_pkg::*;

    logic [COUNT_W-1:0] max_reg;
    phase_t             phase_reg,  phase_next;
    logic [ACC_W-1:0]   acc_reg,    acc_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;
    logic [COUNT_W-1:0] rcvd_reg,   rcvd_next;
    logic [1:0]         skip_reg,   skip_next;
    logic               cr_reg,     cr_next;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg,  out_byte_next;
    logic               out_pay_reg,   out_pay_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic               out_final_reg, out_final_next;

    logic               accept;
    hex_digit_t         hex;
    logic [ACC_W:0]     total;
    logic               too_big;
    logic [COUNT_W-1:0] remain_dec;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign hex        = hex_decode(s_axis_tdata);
    assign total      = {2'b00, rcvd_reg} + {1'b0, acc_reg};
    assign too_big    = total > {2'b00, max_reg};
    assign remain_dec = remain_reg - 1'b1;

    always_comb
    begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        remain_next     = remain_reg;
        rcvd_next       = rcvd_reg;
        skip_next       = skip_reg;
        cr_next         = cr_reg;
        out_byte_next   = '0;
        out_pay_next    = 1'b0;
        out_status_next = ST_BUSY;
        out_final_next  = 1'b0;

        case (phase_reg)
            PH_DONE_OK:
            begin
                out_status_next = ST_OK;
            end
            PH_DONE_BIG:
            begin
                out_status_next = ST_BIG;
            end
            PH_DIGITS, PH_REST, PH_DATA, PH_SKIP:
            begin
                if (s_axis_tlast)
                begin
                    phase_next      = PH_DONE_TRUNC;
                    out_status_next = ST_TRUNC;
                    out_final_next  = 1'b1;
                end
                else
                begin
                    case (phase_reg)
                        PH_DIGITS:
                        begin
                            if (hex.is_digit)
                            begin
                                // saturate once the next shift would overflow
                                if (acc_reg[ACC_W-1:ACC_W-4] != 4'd0)
                                    acc_next = ACC_SAT;
                                else
                                    acc_next = {acc_reg[ACC_W-5:0], hex.value};
                            end
                            else
                            begin
                                cr_next    = (s_axis_tdata == CHAR_CR);
                                phase_next = PH_REST;
                            end
                        end
                        PH_REST:
                        begin
                            if (s_axis_tdata == CHAR_LF && cr_reg)
                            begin
                                cr_next = 1'b0;
                                if (acc_reg == '0)
                                begin
                                    phase_next      = PH_DONE_OK;
                                    out_status_next = ST_OK;
                                    out_final_next  = 1'b1;
                                end
                                else if (too_big)
                                begin
                                    phase_next      = PH_DONE_BIG;
                                    out_status_next = ST_BIG;
                                    out_final_next  = 1'b1;
                                end
                                else
                                begin
                                    remain_next = acc_reg[COUNT_W-1:0];
                                    acc_next    = '0;
                                    phase_next  = PH_DATA;
                                end
                            end
                            else
                            begin
                                cr_next = (s_axis_tdata == CHAR_CR);
                            end
                        end
                        PH_DATA:
                        begin
                            out_byte_next = s_axis_tdata;
                            out_pay_next  = 1'b1;
                            rcvd_next     = rcvd_reg + 1'b1;
                            remain_next   = remain_dec;
                            if (remain_dec == '0)
                            begin
                                phase_next = PH_SKIP;
                                skip_next  = 2'd2;
                            end
                        end
                        PH_SKIP:
                        begin
                            skip_next = skip_reg - 1'b1;
                            if (skip_reg == 2'd1)
                            begin
                                phase_next = PH_DIGITS;
                                acc_next   = '0;
                                cr_next    = 1'b0;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                out_status_next = ST_TRUNC;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= MAX_BODY_RESET;
            phase_reg     <= PH_DIGITS;
            acc_reg       <= '0;
            remain_reg    <= '0;
            rcvd_reg      <= '0;
            skip_reg      <= '0;
            cr_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                max_reg <= cfg_data;
            if (accept)
            begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                remain_reg <= remain_next;
                rcvd_reg   <= rcvd_next;
                skip_reg   <= skip_next;
                cr_reg     <= cr_next;
            end
        end
    end

    // result payload: load on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg   <= out_byte_next;
            out_pay_reg    <= out_pay_next;
            out_status_reg <= out_status_next;
            out_final_reg  <= out_final_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_status_reg, out_pay_reg};
    assign m_axis_tlast  = out_final_reg;

endmodule
`default_nettype wire

>>> hdl/hcbd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_checker: port-level checks of the chunked body decoder
// Watches the stream ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module hcbd_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [2:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);
    import hcbd_pkg::*;

    // every accepted input transaction produces a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after accepted input");

    // a payload byte is only reported while decoding is in progress
    a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == ST_BUSY && !m_axis_tlast)
        else $error("payload byte with terminal status");

    // final flag only together with a terminal status
    a_final_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2:1] != ST_BUSY)
        else $error("final flag without terminal status");

    // non-payload results carry a zero byte
    a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
        else $error("non-payload result with nonzero byte");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
